[hw/rtl/tts_pkg.sv]
// Shared types and constants of the triangle tangent-space block.
`timescale 1ns / 1ps
`default_nettype none
package tts_pkg;
   localparam int Q14_UNIT = 16384;

   // Vector selector for the shared unit-length scaler.
   typedef enum logic [1:0] {
      VEC_NORMAL    = 2'd0,
      VEC_TANGENT   = 2'd1,
      VEC_BITANGENT = 2'd2
   } vec_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load_vtx;
      logic        slot;
      logic        calc_edges;
      logic        calc_prod;
      logic        calc_raw;
      logic        norm_start;
      vec_sel_type norm_sel;
      logic        norm_store;
      logic        rsp_load;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic norm_done;
   } dp_status_type;
endpackage
`default_nettype wire

[hw/rtl/tts_ctrl.sv]
// Controller state machine: sequences vertices, products and normalizations.
`timescale 1ns / 1ps
`default_nettype none
module tts_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic                   rsp_tready,
   output logic                        rsp_tvalid,
   output tts_pkg::ctrl_cmd_type       cmd,
   input  wire tts_pkg::dp_status_type status
);
   typedef enum logic [3:0] {
      S_IDLE, S_EDGE, S_PROD, S_RAW, S_NSTART, S_NWAIT, S_OUT
   } state_type;

   state_type            state_ff, state_in;
   logic [1:0]           phase_ff, phase_in;
   tts_pkg::vec_sel_type sel_ff, sel_in;
   logic                 rv_ff, rv_in;
   logic                 accept;

   // Input is taken in idle; the output register may still hold a result
   // except when a new one has to be written into it.
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rv_ff;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      sel_in   = sel_ff;
      rv_in    = rv_ff && !rsp_tready;
      cmd      = '0;
      cmd.slot = phase_ff[0];
      cmd.norm_sel = sel_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (phase_ff == 2'd2) begin
                  cmd.calc_edges = 1'b1;
                  phase_in = 2'd0;
                  state_in = S_PROD;
               end else begin
                  cmd.load_vtx = 1'b1;
                  phase_in = phase_ff + 2'd1;
               end
            end
         end
         S_EDGE: state_in = S_PROD;
         S_PROD: begin
            cmd.calc_prod = 1'b1;
            state_in = S_RAW;
         end
         S_RAW: begin
            cmd.calc_raw = 1'b1;
            sel_in = tts_pkg::VEC_NORMAL;
            state_in = S_NSTART;
         end
         S_NSTART: begin
            cmd.norm_start = 1'b1;
            state_in = S_NWAIT;
         end
         S_NWAIT: begin
            if (status.norm_done) begin
               cmd.norm_store = 1'b1;
               case (sel_ff)
                  tts_pkg::VEC_NORMAL: begin
                     sel_in = tts_pkg::VEC_TANGENT;
                     state_in = S_NSTART;
                  end
                  tts_pkg::VEC_TANGENT: begin
                     sel_in = tts_pkg::VEC_BITANGENT;
                     state_in = S_NSTART;
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end
         S_OUT: begin
            if (!rv_ff || rsp_tready) begin
               cmd.rsp_load = 1'b1;
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= 2'd0;
         sel_ff   <= tts_pkg::VEC_NORMAL;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         sel_ff   <= sel_in;
         rv_ff    <= rv_in;
      end
   end
endmodule
`default_nettype wire

[hw/rtl/tts_norm.sv]
// Shared multi-cycle unit that scales a 3-vector to unit length in Q1.14.
`timescale 1ns / 1ps
`default_nettype none
module tts_norm (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [47:0] vec_x,
   input  wire logic signed [47:0] vec_y,
   input  wire logic signed [47:0] vec_z,
   output logic                    done,
   output logic signed [15:0]      unit_x,
   output logic signed [15:0]      unit_y,
   output logic signed [15:0]      unit_z
);
   typedef enum logic [2:0] {
      N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DIV, N_DONE
   } nstate_type;

   nstate_type       st_ff;
   logic [47:0]      mag_ff [3];
   logic [2:0]       neg_ff;
   logic [47:0]      m_ff;
   logic [1:0]       k_ff;
   logic [61:0]      sum_ff;
   logic [61:0]      rem_ff;
   logic [31:0]      root_ff;
   logic [4:0]       it_ff;
   logic [47:0]      num_ff;
   logic [31:0]      den_ff;
   logic [15:0]      quo_ff;
   logic [15:0]      q_ff [3];
   logic [5:0]       bit_ff;
   logic [47:0]      m_or;
   logic [47:0]      sh_m;
   logic [63:0]      sq;
   logic [32:0]      div_win;
   logic             div_ge;

   assign m_or = (vec_x[47] ? -vec_x : vec_x) | (vec_y[47] ? -vec_y : vec_y)
               | (vec_z[47] ? -vec_z : vec_z);
   assign sh_m = m_ff;
   assign sq   = {32'd0, mag_ff[k_ff][31:0]} * {32'd0, mag_ff[k_ff][31:0]};

   // The partial remainder can reach twice the divisor before the compare,
   // so the window is one bit wider than the divisor.
   assign div_win = num_ff[47:15];
   assign div_ge  = div_win >= {1'b0, den_ff};

   logic [63:0] root_trial;
   logic [63:0] rem_top;
   assign root_trial = {30'd0, root_ff, 2'b01};
   assign rem_top    = {rem_ff, sum_ff[61:60]};

   always_ff @(posedge clock) begin
      if (reset) begin
         done <= 1'b0;
         st_ff <= N_IDLE;
      end else begin
         done <= (st_ff == N_DONE);
         case (st_ff)
            N_IDLE: begin
               if (start) begin
                  mag_ff[0] <= vec_x[47] ? -vec_x : vec_x;
                  mag_ff[1] <= vec_y[47] ? -vec_y : vec_y;
                  mag_ff[2] <= vec_z[47] ? -vec_z : vec_z;
                  neg_ff <= {vec_z[47], vec_y[47], vec_x[47]};
                  m_ff <= m_or;
                  if (m_or == '0) begin
                     q_ff[0] <= '0;
                     q_ff[1] <= '0;
                     q_ff[2] <= '0;
                     st_ff <= N_DONE;
                  end else begin
                     st_ff <= N_SHIFT;
                  end
               end
            end
            // One bit a cycle until the largest bit sits at position 29.
            N_SHIFT: begin
               if (sh_m[47:30] != '0) begin
                  m_ff <= m_ff >> 1;
                  for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] >> 1;
               end else if (!sh_m[29]) begin
                  m_ff <= m_ff << 1;
                  for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] << 1;
               end else begin
                  sum_ff <= '0;
                  k_ff <= 2'd0;
                  st_ff <= N_SQ;
               end
            end
            N_SQ: begin
               sum_ff <= sum_ff + sq[61:0];
               if (k_ff == 2'd2) begin
                  rem_ff <= '0;
                  root_ff <= '0;
                  it_ff <= 5'd0;
                  st_ff <= N_SQRT;
               end else begin
                  k_ff <= k_ff + 2'd1;
               end
            end
            // Restoring square root, one result bit a cycle.
            N_SQRT: begin
               sum_ff <= {sum_ff[59:0], 2'b00};
               if (rem_top >= root_trial) begin
                  rem_ff <= rem_top[61:0] - root_trial[61:0];
                  root_ff <= {root_ff[30:0], 1'b1};
               end else begin
                  rem_ff <= rem_top[61:0];
                  root_ff <= {root_ff[30:0], 1'b0};
               end
               if (it_ff == 5'd30) begin
                  k_ff <= 2'd0;
                  st_ff <= N_DIV;
                  bit_ff <= 6'd0;
               end
               it_ff <= it_ff + 5'd1;
            end
            // Restoring division (|c|*32768 + L) / (2L), one bit a cycle.
            N_DIV: begin
               if (bit_ff == 6'd0) begin
                  num_ff <= {1'b0, mag_ff[k_ff][31:0], 15'd0} + {17'd0, root_ff[30:0]};
                  den_ff <= {root_ff[30:0], 1'b0};
                  quo_ff <= '0;
                  bit_ff <= 6'd1;
               end else begin
                  if (div_ge) begin
                     num_ff <= {div_win - {1'b0, den_ff}, num_ff[14:0]} << 1;
                     quo_ff <= {quo_ff[14:0], 1'b1};
                  end else begin
                     num_ff <= num_ff << 1;
                     quo_ff <= {quo_ff[14:0], 1'b0};
                  end
                  if (bit_ff == 6'd16) begin
                     bit_ff <= 6'd0;
                     q_ff[k_ff] <= {quo_ff[14:0], div_ge};
                     if (k_ff == 2'd2) st_ff <= N_DONE;
                     k_ff <= k_ff + 2'd1;
                  end else begin
                     bit_ff <= bit_ff + 6'd1;
                  end
               end
            end
            N_DONE: begin
               st_ff <= N_IDLE;
            end
            default: st_ff <= N_IDLE;
         endcase
      end
   end

   always_comb begin
      unit_x = neg_ff[0] ? -q_ff[0] : q_ff[0];
      unit_y = neg_ff[1] ? -q_ff[1] : q_ff[1];
      unit_z = neg_ff[2] ? -q_ff[2] : q_ff[2];
   end
endmodule
`default_nettype wire

[hw/rtl/tts_datapath.sv]
// Datapath: vertex holding, edge and product arithmetic, result register.
`timescale 1ns / 1ps
`default_nettype none
module tts_datapath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire tts_pkg::ctrl_cmd_type  cmd,
   output tts_pkg::dp_status_type      status,
   input  wire logic                   bitangent_enable,
   input  wire logic [79:0]            vtx,
   output logic [143:0]                rsp_data,
   output logic [1:0]                  rsp_flags
);
   logic signed [15:0] pos_ff [6];
   logic signed [15:0] tex_ff [4];
   logic signed [16:0] e1_ff [3], e2_ff [3];
   logic signed [16:0] du1_ff, dv1_ff, du2_ff, dv2_ff;
   logic signed [33:0] p_ff [8];
   logic signed [47:0] nrm_ff [3], tan_ff [3], bit_ff [3];
   logic               uvz_ff, arz_ff;
   logic signed [15:0] res_ff [9];
   logic signed [47:0] nv [3];
   logic signed [15:0] ux, uy, uz;
   logic               ndone;
   logic signed [15:0] vin [5];
   logic signed [34:0] det;

   always_comb begin
      for (int i = 0; i < 5; i++) vin[i] = vtx[16*i +: 16];
      case (cmd.norm_sel)
         tts_pkg::VEC_NORMAL: begin
            for (int i = 0; i < 3; i++) nv[i] = arz_ff ? '0 : nrm_ff[i];
         end
         tts_pkg::VEC_TANGENT: begin
            for (int i = 0; i < 3; i++) nv[i] = uvz_ff ? '0 : tan_ff[i];
         end
         default: begin
            for (int i = 0; i < 3; i++)
               nv[i] = (uvz_ff || !bitangent_enable) ? '0 : bit_ff[i];
         end
      endcase
   end

   tts_norm u_norm (
      .clock(clock), .reset(reset), .start(cmd.norm_start),
      .vec_x(nv[0]), .vec_y(nv[1]), .vec_z(nv[2]),
      .done(ndone), .unit_x(ux), .unit_y(uy), .unit_z(uz)
   );
   assign status.norm_done = ndone;

   // Products: 0..5 cross terms, 6..7 determinant terms; tangent and
   // bitangent terms are formed one step later.
   assign det = 35'(p_ff[6]) - 35'(p_ff[7]);

   always_ff @(posedge clock) begin
      if (cmd.load_vtx) begin
         for (int i = 0; i < 3; i++) pos_ff[3*cmd.slot + i] <= vin[i];
         tex_ff[2*cmd.slot]     <= vin[3];
         tex_ff[2*cmd.slot + 1] <= vin[4];
      end
      if (cmd.calc_edges) begin
         for (int i = 0; i < 3; i++) begin
            e1_ff[i] <= 17'(pos_ff[3+i]) - 17'(pos_ff[i]);
            e2_ff[i] <= 17'(vin[i]) - 17'(pos_ff[i]);
         end
         du1_ff <= 17'(tex_ff[2]) - 17'(tex_ff[0]);
         dv1_ff <= 17'(tex_ff[3]) - 17'(tex_ff[1]);
         du2_ff <= 17'(vin[3]) - 17'(tex_ff[0]);
         dv2_ff <= 17'(vin[4]) - 17'(tex_ff[1]);
      end
      if (cmd.calc_prod) begin
         p_ff[0] <= e1_ff[1] * e2_ff[2];
         p_ff[1] <= e1_ff[2] * e2_ff[1];
         p_ff[2] <= e1_ff[2] * e2_ff[0];
         p_ff[3] <= e1_ff[0] * e2_ff[2];
         p_ff[4] <= e1_ff[0] * e2_ff[1];
         p_ff[5] <= e1_ff[1] * e2_ff[0];
         p_ff[6] <= du1_ff * dv2_ff;
         p_ff[7] <= du2_ff * dv1_ff;
      end
      if (cmd.calc_raw) begin
         for (int i = 0; i < 3; i++) begin
            tan_ff[i] <= (det < 0) ?
               48'(dv1_ff * e2_ff[i]) - 48'(dv2_ff * e1_ff[i]) :
               48'(dv2_ff * e1_ff[i]) - 48'(dv1_ff * e2_ff[i]);
            bit_ff[i] <= (det < 0) ?
               48'(du2_ff * e1_ff[i]) - 48'(du1_ff * e2_ff[i]) :
               48'(du1_ff * e2_ff[i]) - 48'(du2_ff * e1_ff[i]);
         end
         nrm_ff[0] <= 48'(p_ff[0]) - 48'(p_ff[1]);
         nrm_ff[1] <= 48'(p_ff[2]) - 48'(p_ff[3]);
         nrm_ff[2] <= 48'(p_ff[4]) - 48'(p_ff[5]);
         uvz_ff <= (det == 0);
         arz_ff <= (p_ff[0] == p_ff[1]) && (p_ff[2] == p_ff[3]) && (p_ff[4] == p_ff[5]);
      end
      if (cmd.norm_store) begin
         res_ff[3*cmd.norm_sel]     <= ux;
         res_ff[3*cmd.norm_sel + 1] <= uy;
         res_ff[3*cmd.norm_sel + 2] <= uz;
      end
      if (cmd.rsp_load) begin
         for (int i = 0; i < 9; i++) rsp_data[16*i +: 16] <= res_ff[i];
         rsp_flags <= {arz_ff, uvz_ff};
      end
   end
endmodule
`default_nettype wire

[hw/rtl/triangle_tangent_space.sv]
// Top level: per-triangle normal, tangent and bitangent from a vertex stream.
//
// Channel   Direction  Content
// req_      in         one vertex per item: position Q7.8, texcoord Q3.12
// rsp_      out        one result per third vertex: unit vectors Q1.14, flags
// csr_      in/out     APB register bitangent_enable at address 0
//
// Vertices 0 and 1 of a triangle are only stored. After vertex 2 the block forms
// the products and the raw vectors, runs the shared normalizer three times (each
// run 1 to 30 shift steps, three squares, a 31-step square root, three 16-bit
// divisions, or straight to done for a zero vector) and then loads the output;
// no new vertex is taken before that load.
// Reset is synchronous; the result register holds a result until rsp_tready
// while the block works on, and a waiting result stalls the output load.
`timescale 1ns / 1ps
`default_nettype none
module triangle_tangent_space (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // pos_x, pos_y, pos_z, tex_u, tex_v
   input  wire logic [79:0]  req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // normal_x/y/z, tangent_x/y/z, bitangent_x/y/z
   output logic [143:0]      rsp_tdata,
   // uv_degenerate, area_degenerate
   output logic [1:0]        rsp_tuser,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [0:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   tts_pkg::ctrl_cmd_type  cmd;
   tts_pkg::dp_status_type status;
   logic bt_en_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = {31'd0, bt_en_ff};
   always_ff @(posedge clock) begin
      if (reset) bt_en_ff <= 1'b0;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 1'b0)
         bt_en_ff <= csr_pwdata[0];
   end

   tts_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid),
      .req_tready(req_tready), .rsp_tready(rsp_tready),
      .rsp_tvalid(rsp_tvalid), .cmd(cmd), .status(status)
   );

   tts_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .bitangent_enable(bt_en_ff), .vtx(req_tdata),
      .rsp_data(rsp_tdata), .rsp_flags(rsp_tuser)
   );
endmodule
`default_nettype wire

[tb/tb_triangle_tangent_space.sv]
// Self-checking testbench for the triangle tangent-space block.
`timescale 1ns / 1ps
module tb_triangle_tangent_space;
   localparam int IDLE_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 400;

   typedef struct {
      logic [143:0] vectors;
      logic [1:0]   flags;
   } face_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid, req_tready;
   logic [79:0]  req_tdata;
   logic         rsp_tvalid, rsp_tready;
   logic [143:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_psel, csr_penable, csr_pwrite;
   logic [0:0]   csr_paddr;
   logic [31:0]  csr_pwdata, csr_prdata;
   logic         csr_pready;

   logic [79:0]     vertex_queue[$];
   face_result_type face_queue[$];
   longint          held_pos[6];
   longint          held_tex[4];
   int              vertex_slot = 0;
   bit              bitangent_on = 1'b0;
   bit              hold_sender = 1'b0;
   int              send_idle = 0;
   int              recv_idle = 0;
   int              fail_count = 0;
   int              idle_cycles = 0;
   string           field_names[9] = '{"normal_x", "normal_y", "normal_z", "tangent_x",
                                       "tangent_y", "tangent_z", "bitangent_x",
                                       "bitangent_y", "bitangent_z"};

   triangle_tangent_space i_dut (.*);

   always #1 clock = ~clock;

   function automatic longint unsigned root_floor(input longint unsigned n);
      longint unsigned r = 0;
      longint unsigned b = 64'h4000_0000_0000_0000;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   // Unit length in Q1.14, packed as {z, y, x}.
   function automatic logic [47:0] unit_q14(input longint vx, input longint vy,
                                            input longint vz);
      longint          v[3];
      longint unsigned mag[3];
      bit              neg[3];
      longint unsigned m, len, q;
      logic [47:0]     res;
      v = '{vx, vy, vz};
      m = 0;
      res = '0;
      for (int k = 0; k < 3; k++) begin
         neg[k] = v[k] < 0;
         mag[k] = neg[k] ? longint'(-v[k]) : v[k];
         if (mag[k] > m) m = mag[k];
      end
      if (m == 0) return res;
      while (m >= (64'd1 << 30)) begin
         m >>= 1;
         for (int k = 0; k < 3; k++) mag[k] >>= 1;
      end
      while (m < (64'd1 << 29)) begin
         m <<= 1;
         for (int k = 0; k < 3; k++) mag[k] <<= 1;
      end
      len = root_floor(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
      for (int k = 0; k < 3; k++) begin
         q = (mag[k] * 32768 + len) / (2 * len);
         if (q > tts_pkg::Q14_UNIT) q = tts_pkg::Q14_UNIT;
         res[16*k +: 16] = neg[k] ? 16'(-q) : 16'(q);
      end
      return res;
   endfunction

   task automatic predict_face(input logic [79:0] vtx);
      longint          p[3], t[2], e1[3], e2[3], nrm[3], tng[3], btg[3];
      longint          du1, dv1, du2, dv2, det;
      face_result_type r;
      for (int k = 0; k < 3; k++) p[k] = longint'($signed(vtx[16*k +: 16]));
      for (int k = 0; k < 2; k++) t[k] = longint'($signed(vtx[48 + 16*k +: 16]));
      if (vertex_slot < 2) begin
         for (int k = 0; k < 3; k++) held_pos[vertex_slot*3 + k] = p[k];
         for (int k = 0; k < 2; k++) held_tex[vertex_slot*2 + k] = t[k];
         vertex_slot++;
         return;
      end
      vertex_slot = 0;
      for (int k = 0; k < 3; k++) begin
         e1[k] = held_pos[3 + k] - held_pos[k];
         e2[k] = p[k] - held_pos[k];
      end
      du1 = held_tex[2] - held_tex[0];
      dv1 = held_tex[3] - held_tex[1];
      du2 = t[0] - held_tex[0];
      dv2 = t[1] - held_tex[1];
      nrm[0] = e1[1] * e2[2] - e1[2] * e2[1];
      nrm[1] = e1[2] * e2[0] - e1[0] * e2[2];
      nrm[2] = e1[0] * e2[1] - e1[1] * e2[0];
      det = du1 * dv2 - du2 * dv1;
      r.vectors = '0;
      r.flags[1] = nrm[0] == 0 && nrm[1] == 0 && nrm[2] == 0;
      r.flags[0] = det == 0;
      r.vectors[47:0] = unit_q14(nrm[0], nrm[1], nrm[2]);
      if (det != 0) begin
         for (int k = 0; k < 3; k++) begin
            tng[k] = dv2 * e1[k] - dv1 * e2[k];
            btg[k] = du1 * e2[k] - du2 * e1[k];
            if (det < 0) begin
               tng[k] = -tng[k];
               btg[k] = -btg[k];
            end
         end
         r.vectors[95:48] = unit_q14(tng[0], tng[1], tng[2]);
         if (bitangent_on) r.vectors[143:96] = unit_q14(btg[0], btg[1], btg[2]);
      end
      face_queue = {face_queue, r};
   endtask

   // Vertex driver and receiver backpressure.
   always @(posedge clock) begin
      logic        nv;
      logic [79:0] nd;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         rsp_tready <= 1'b0;
      end else begin
         nv = req_tvalid;
         nd = req_tdata;
         if (req_tvalid && req_tready) begin
            predict_face(req_tdata);
            void'(vertex_queue.pop_front());
            nv = 1'b0;
         end
         if (!nv && vertex_queue.size() > 0 && !hold_sender &&
             $urandom_range(0, 99) >= send_idle) begin
            nv = 1'b1;
            nd = vertex_queue[0];
         end
         req_tvalid <= nv;
         req_tdata <= nd;
         rsp_tready <= $urandom_range(0, 99) >= recv_idle;
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      face_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (face_queue.size() == 0) begin
            $error("unexpected result item %h", rsp_tdata);
            fail_count++;
         end else begin
            want = face_queue.pop_front();
            for (int k = 0; k < 9; k++)
               if (rsp_tdata[16*k +: 16] !== want.vectors[16*k +: 16]) begin
                  $error("%s: expected %0d, got %0d", field_names[k],
                         $signed(want.vectors[16*k +: 16]),
                         $signed(rsp_tdata[16*k +: 16]));
                  fail_count++;
               end
            if (rsp_tuser[0] !== want.flags[0]) begin
               $error("uv_degenerate: expected %0d, got %0d", want.flags[0], rsp_tuser[0]);
               fail_count++;
            end
            if (rsp_tuser[1] !== want.flags[1]) begin
               $error("area_degenerate: expected %0d, got %0d", want.flags[1],
                      rsp_tuser[1]);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_triangle_tangent_space NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [79:0] vertex(input int px, input int py, input int pz,
                                          input int tu, input int tv);
      return {16'(tv), 16'(tu), 16'(pz), 16'(py), 16'(px)};
   endfunction

   function automatic int coord(input int span);
      return span == 0 ? int'($signed(16'($urandom))) : $urandom_range(0, 2*span) - span;
   endfunction

   task automatic queue_vertex(input logic [79:0] v);
      vertex_queue = {vertex_queue, v};
   endtask

   task automatic push_random_faces(input int count);
      int          shape, span;
      logic [79:0] v0, v1, v2;
      for (int n = 0; n < count; n++) begin
         shape = $urandom_range(0, 9);
         span = shape < 5 ? 0 : (shape < 7 ? 64 : 2000);
         v0 = vertex(coord(span), coord(span), coord(span), coord(span), coord(span));
         v1 = vertex(coord(span), coord(span), coord(span), coord(span), coord(span));
         v2 = vertex(coord(span), coord(span), coord(span), coord(span), coord(span));
         // Shared positions give a zero-area face; shared texcoords a flat uv map.
         if (shape == 7) v1[47:0] = v0[47:0];
         if (shape == 8) begin
            v1[79:48] = v0[79:48];
            v2[79:48] = v0[79:48];
         end
         if (shape == 9) v2[47:0] = v0[47:0] + ((v1[47:0] - v0[47:0]) & 48'h0);
         queue_vertex(v0);
         queue_vertex(v1);
         queue_vertex(v2);
      end
   endtask

   task automatic drain;
      while (vertex_queue.size() > 0 || req_tvalid || face_queue.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_enable(input bit value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= '0;
      csr_pwdata <= {$urandom() & 32'hFFFF_FFFE, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      bitangent_on = value;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   initial begin
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed faces with the bitangent off, then on.
      send_idle = 35;
      recv_idle = 64;
      for (int pass = 0; pass < 2; pass++) begin
         if (pass == 1) write_enable(1'b1);
         queue_vertex(vertex(0, 0, 0, 0, 0));
         queue_vertex(vertex(256, 0, 0, 4096, 0));
         queue_vertex(vertex(0, 256, 0, 0, 4096));
         // Extreme coordinates.
         queue_vertex(vertex(-32768, -32768, -32768, -32768, -32768));
         queue_vertex(vertex(32767, -32768, 32767, 32767, -32768));
         queue_vertex(vertex(-32768, 32767, 32767, -32768, 32767));
         // Collinear points.
         queue_vertex(vertex(0, 0, 0, 0, 0));
         queue_vertex(vertex(100, 200, 300, 4096, 0));
         queue_vertex(vertex(200, 400, 600, 0, 4096));
         // Flat uv map.
         queue_vertex(vertex(0, 0, 0, 77, 88));
         queue_vertex(vertex(300, 0, 5, 77, 88));
         queue_vertex(vertex(0, 300, 9, 77, 88));
         // One point with distinct uvs: zero area and zero tangent.
         queue_vertex(vertex(5, 5, 5, 0, 0));
         queue_vertex(vertex(5, 5, 5, 4096, 0));
         queue_vertex(vertex(5, 5, 5, 0, 4096));
         // Positive determinant and a bitangent along the axis.
         queue_vertex(vertex(32767, 32767, 32767, 32767, 32767));
         queue_vertex(vertex(-32768, 32767, 32767, -32768, 32767));
         queue_vertex(vertex(32767, -32768, 32767, 32767, 32767 - 1));
         drain();
      end

      push_random_faces(36);
      // Stop sending until every result is back.
      while (vertex_queue.size() > 40) @(posedge clock);
      hold_sender = 1'b1;
      while (req_tvalid || face_queue.size() > 0) @(posedge clock);
      repeat (30) @(posedge clock);
      hold_sender = 1'b0;
      push_random_faces(36);
      drain();

      write_enable(1'b0);
      send_idle = 64;
      recv_idle = 35;
      push_random_faces(72);
      drain();

      write_enable(1'b1);
      send_idle = 0;
      recv_idle = 0;
      push_random_faces(60);
      drain();

      if (fail_count == 0) begin
         $display("tb_triangle_tangent_space OK");
      end else begin
         $display("tb_triangle_tangent_space NOT OK");
      end
      $finish;
   end
endmodule

[triangle_tangent_space.f]
hw/rtl/tts_pkg.sv
hw/rtl/tts_ctrl.sv
hw/rtl/tts_norm.sv
hw/rtl/tts_datapath.sv
hw/rtl/triangle_tangent_space.sv
tb/tb_triangle_tangent_space.sv
